// File: sv/met_pkg.sv
// ============================================================================
// met_pkg: shared types and constants for the escape-time engine
// fixed point formats, configuration layout, request payloads, control types
// ============================================================================
package met_pkg;

    // coordinate and fixed point formats
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 28;
    localparam int WORD_BITS  = 32;
    localparam int PROD_BITS  = 2 * WORD_BITS;

    // escape threshold of 4.0 in the product format, if representable
    localparam bit          HAS_LIMIT = (2 * FRAC_BITS + 2) < PROD_BITS;
    localparam int          LIMIT_SH  = HAS_LIMIT ? (2 * FRAC_BITS + 2) : 0;
    localparam logic [63:0] MAG_LIMIT = 64'd1 << LIMIT_SH;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITERS = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_LEFT    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_STEP    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_LOWER   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_STEP    = 3'd4;

    // configuration reset values
    localparam logic [15:0]        RST_MAX_ITERS = 16'd256;
    localparam logic signed [31:0] RST_X_LEFT    = -32'sd536870912;
    localparam logic signed [31:0] RST_X_STEP    = 32'sd1048576;
    localparam logic signed [31:0] RST_Y_LOWER   = -32'sd536870912;
    localparam logic signed [31:0] RST_Y_STEP    = 32'sd1048576;

    typedef struct packed {
        logic [15:0]        max_iters;
        logic signed [31:0] x_left;
        logic signed [31:0] x_step;
        logic signed [31:0] y_lower;
        logic signed [31:0] y_step;
    } t_cfg;

    // request payloads
    typedef struct packed {
        logic [11:0] column;
        logic [11:0] pixel_row;
    } t_in_item;

    typedef struct packed {
        logic [11:0] out_column;
        logic [11:0] out_row;
        logic [15:0] escape_count;
    } t_out_item;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_MUL,
        S_MAP_ADD,
        S_SQUARE,
        S_STEP,
        S_EMIT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic map_mul;
        logic map_add;
        logic square;
        logic step;
        logic emit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic escape;
        logic at_limit;
        logic out_free;
    } t_dp_stat;

    // saturate a wide signed value to a 32-bit word
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if ((&v[65:31]) || !(|v[65:31])) begin
            r = v[31:0];
        end else if (v[65]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

// File: sv/mandelbrot_escape_time.sv
// ============================================================================
// mandelbrot_escape_time: escape-time iteration engine, one pixel per request
// maps a pixel to c and counts z = z*z + c passes until escape or the limit
//
//   channel  direction  signals                              payload
//   in       input      i_in_valid, o_in_stall, i_in         t_in_item
//   out      output     o_out_valid, i_out_stall, o_out      t_out_item
//   cfg      input      i_cfg_we, i_cfg_index, i_cfg_wdata   32-bit register data
//
// a pixel holds the engine while it takes the request and maps the point, then
// for each pass runs three 32x32 multiplies and then the add and escape test,
// with one last pass that finds the stop, and then moves the result into the
// output register and sets its valid.
// reset clears the controller and output valid and loads the register defaults.
// a result waiting under stall holds in the output register while the next
// request is taken and iterated; only a second finished result waits for it.
// ============================================================================
module mandelbrot_escape_time import met_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_item               o_out,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [31:0]             i_cfg_wdata
);

    t_cfg     w_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // configuration registers
    met_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // sequencer
    met_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // arithmetic and output register
    met_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// File: sv/met_cfg_regs.sv
// ============================================================================
// met_cfg_regs: configuration register bank
// write-only registers for iteration limit and plane mapping
// ============================================================================
module met_cfg_regs import met_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [31:0]             i_cfg_wdata,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register decode, unknown indexes are ignored
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_ITERS: n_cfg.max_iters = i_cfg_wdata[15:0];
                CFG_X_LEFT:    n_cfg.x_left    = i_cfg_wdata;
                CFG_X_STEP:    n_cfg.x_step    = i_cfg_wdata;
                CFG_Y_LOWER:   n_cfg.y_lower   = i_cfg_wdata;
                CFG_Y_STEP:    n_cfg.y_step    = i_cfg_wdata;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_iters <= RST_MAX_ITERS;
            r_cfg.x_left    <= RST_X_LEFT;
            r_cfg.x_step    <= RST_X_STEP;
            r_cfg.y_lower   <= RST_Y_LOWER;
            r_cfg.y_step    <= RST_Y_STEP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/met_ctrl.sv
// ============================================================================
// met_ctrl: sequencing state machine
// steps one pixel through mapping, iteration and hand-off to the output
// ============================================================================
module met_ctrl import met_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall
);

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_in_valid) begin
                n_state = S_MAP_MUL;
            end
            S_MAP_MUL: n_state = S_MAP_ADD;
            S_MAP_ADD: n_state = S_SQUARE;
            S_SQUARE:  n_state = S_STEP;
            S_STEP:    if (i_stat.escape || i_stat.at_limit) begin
                n_state = S_EMIT;
            end else begin
                n_state = S_SQUARE;
            end
            S_EMIT:    if (i_stat.out_free) begin
                n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_MAP_MUL: o_cmd.map_mul = 1'b1;
            S_MAP_ADD: o_cmd.map_add = 1'b1;
            S_SQUARE:  o_cmd.square  = 1'b1;
            S_STEP:    o_cmd.step    = !(i_stat.escape || i_stat.at_limit);
            S_EMIT:    o_cmd.emit    = i_stat.out_free;
            default:   o_cmd         = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/met_dpath.sv
// ============================================================================
// met_dpath: escape-time datapath
// point mapping, z = z*z + c iteration, escape test and output register
// ============================================================================
module met_dpath import met_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_in_item  i_in,
    input  t_dp_cmd   i_cmd,
    input  logic      i_out_stall,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    output t_out_item o_out
);

    localparam int MAP_BITS = COORD_BITS + 1 + WORD_BITS;

    // pixel and point
    logic [COORD_BITS-1:0]      r_col;
    logic [COORD_BITS-1:0]      r_row;
    logic signed [MAP_BITS-1:0] r_px;
    logic signed [MAP_BITS-1:0] r_py;
    logic signed [31:0]         r_cx;
    logic signed [31:0]         r_cy;

    // iteration state
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [63:0] r_xx;
    logic signed [63:0] r_yy;
    logic signed [63:0] r_xy;
    logic [15:0]        r_count;

    // output register
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;

    logic [63:0]        w_mag;
    logic signed [64:0] w_diff;
    logic signed [64:0] w_re;
    logic signed [63:0] w_im;
    logic signed [31:0] w_nx;
    logic signed [31:0] w_ny;

    // escape test on the squares of the current z
    assign w_mag = $unsigned(r_xx) + $unsigned(r_yy);

    // next z, floored and saturated
    assign w_diff = 65'(r_xx) - 65'(r_yy);
    assign w_re   = w_diff >>> FRAC_BITS;
    assign w_im   = r_xy >>> (FRAC_BITS - 1);
    assign w_nx   = sat32(66'(w_re) + 66'(r_cx));
    assign w_ny   = sat32(66'(w_im) + 66'(r_cy));

    assign o_stat.escape   = HAS_LIMIT && (w_mag >= MAG_LIMIT);
    assign o_stat.at_limit = (r_count == i_cfg.max_iters);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col <= COORD_BITS'(i_in.column);
            r_row <= COORD_BITS'(i_in.pixel_row);
        end
        if (i_cmd.map_mul) begin
            r_px <= $signed({1'b0, r_col}) * i_cfg.x_step;
            r_py <= $signed({1'b0, r_row}) * i_cfg.y_step;
        end
        if (i_cmd.map_add) begin
            r_cx    <= sat32(66'(r_px) + 66'(i_cfg.x_left));
            r_cy    <= sat32(66'(r_py) + 66'(i_cfg.y_lower));
            r_x     <= '0;
            r_y     <= '0;
            r_count <= '0;
        end
        if (i_cmd.square) begin
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_xy <= r_x * r_y;
        end
        if (i_cmd.step) begin
            r_x     <= w_nx;
            r_y     <= w_ny;
            r_count <= r_count + 16'd1;
        end
        if (i_cmd.emit) begin
            r_out.out_column   <= 12'(r_col);
            r_out.out_row      <= 12'(r_row);
            r_out.escape_count <= r_count;
        end
    end

    // output valid: set on emit, cleared once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
